>>> rtl/core/bcfp_pkg.sv
// Shared types and constants of the BiSS-C frame parser.
// No dependencies; bcfp_front, bcfp_fifo, bcfp_back and the top level import this package.
`default_nettype none

package bcfp_pkg;

   localparam int unsigned MAX_FRAME_BITS = 128;
   localparam int unsigned SEEN_W         = $clog2(MAX_FRAME_BITS + 1);
   localparam int unsigned FIFO_DEPTH     = 4;
   localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned CRC_W    = 6;
   localparam logic [CRC_W-1:0] CRC_POLY = 6'h03;   // x^6 + x + 1, top term implied
   localparam int unsigned POS_W    = 32;
   localparam int unsigned PBITS_W  = 6;
   localparam int unsigned ZRUN_W   = 7;
   localparam logic [ZRUN_W-1:0] ZRUN_MAX = 7'd127;
   localparam int unsigned FLAG_BITS = 2;

   // register indexes of the configuration port
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ZEROS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ZEROS     = 2'd2;

   localparam logic [PBITS_W-1:0] POSITION_BITS_RST = 6'd26;
   localparam logic [ZRUN_W-1:0]  MIN_ZEROS_RST     = 7'd4;
   localparam logic [ZRUN_W-1:0]  MAX_ZEROS_RST     = 7'd40;

   typedef struct packed {
      logic [PBITS_W-1:0] position_bits;
      logic [ZRUN_W-1:0]  min_zeros;
      logic [ZRUN_W-1:0]  max_zeros;
   } cfg_type;

   // one queued beat: line bits, how many of them to scan, frame end mark
   typedef struct packed {
      logic [7:0] line_byte;
      logic [3:0] nbits;
      logic       last_byte;
   } entry_type;

   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic bit_in);
      logic top;
      top = crc[CRC_W-1] ^ bit_in;
      return {crc[CRC_W-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcfp_req_if.sv
// Input channel of the frame parser: captured line bytes.
// No dependencies.
`default_nettype none

interface bcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       last_byte;

   modport source (output valid, line_byte, last_byte, input ready);
   modport sink   (input valid, line_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bcfp_rsp_if.sv
// Result channel of the frame parser: one decoded frame per beat.
// No dependencies.
`default_nettype none

interface bcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [31:0] position;
   logic        error_flag;
   logic        warning_flag;
   logic        crc_ok;

   modport source (output valid, frame_ok, position, error_flag, warning_flag, crc_ok,
                   input ready);
   modport sink   (input valid, frame_ok, position, error_flag, warning_flag, crc_ok,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/bcfp_csr_if.sv
// Configuration write channel of the frame parser.
// No dependencies.
`default_nettype none

interface bcfp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bcfp_front.sv
// Front end: accepts line bytes and tags each with the number of bits
// still inside the frame capacity. Depends on bcfp_pkg, bcfp_req_if.
`default_nettype none

module bcfp_front import bcfp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   bcfp_req_if.sink       req_ch,
   input  wire logic      q_full,
   output logic           q_push,
   output entry_type      q_entry
);

   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SEEN_W-1:0] remain;
   logic [3:0]        nbits;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   assign remain = SEEN_W'(MAX_FRAME_BITS) - seen_ff;
   assign nbits  = (remain >= SEEN_W'(8)) ? 4'd8 : remain[3:0];

   assign q_entry.line_byte = req_ch.line_byte;
   assign q_entry.nbits     = nbits;
   assign q_entry.last_byte = req_ch.last_byte;

   always_comb begin
      seen_in = seen_ff;
      if (q_push) begin
         if (req_ch.last_byte) begin
            seen_in = '0;
         end else begin
            seen_in = seen_ff + SEEN_W'(nbits);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bcfp_fifo.sv
// Short queue between front and back end.
// Depends on bcfp_pkg.
`default_nettype none

module bcfp_fifo import bcfp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   output logic           full,
   input  wire logic      pop,
   output entry_type      pop_data,
   output logic           not_empty
);

   entry_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bcfp_back.sv
// Back end: bit-serial frame scanner, CRC-6 check and result register.
// Depends on bcfp_pkg, bcfp_rsp_if.
`default_nettype none

module bcfp_back import bcfp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire entry_type q_entry,
   output logic           q_pop,
   bcfp_rsp_if.source     rsp_ch
);

   typedef enum logic [2:0] {
      PH_SEEK_ONE  = 3'd0,
      PH_SEEK_ZERO = 3'd1,
      PH_COUNT     = 3'd2,
      PH_AFTER_ONE = 3'd3,
      PH_POSITION  = 3'd4,
      PH_FLAGS     = 3'd5,
      PH_CHECK     = 3'd6,
      PH_DONE      = 3'd7
   } phase_type;

   // beat being scanned
   logic               busy_ff;
   logic [7:0]         byte_ff;
   logic [3:0]         cnt_ff;
   logic               last_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [ZRUN_W-1:0]  zrun_ff, zrun_in;
   logic [PBITS_W-1:0] fidx_ff, fidx_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [FLAG_BITS-1:0] flags_ff, flags_in;
   logic [CRC_W-1:0]   rxcrc_ff, rxcrc_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;

   // result register
   logic               rsp_valid_ff;
   logic               ok_ff;
   logic [POS_W-1:0]   rpos_ff;
   logic               err_ff, warn_ff, crcok_ff;

   logic bit_now, finish, emit, stall, advance, take, load, frame_ok;

   assign bit_now = byte_ff[7];
   assign finish  = busy_ff && (cnt_ff <= 4'd1);
   assign emit    = finish && last_ff;
   assign stall   = emit && rsp_valid_ff && !rsp_ch.ready;
   assign advance = busy_ff && !stall;
   assign take    = advance && (cnt_ff != 4'd0);
   assign load    = (!busy_ff || (finish && !stall)) && q_valid;
   assign q_pop   = load;

   // one scanner step on the current line bit
   always_comb begin
      phase_in = phase_ff;
      zrun_in  = zrun_ff;
      fidx_in  = fidx_ff;
      pos_in   = pos_ff;
      flags_in = flags_ff;
      rxcrc_in = rxcrc_ff;
      crc_in   = crc_ff;
      if (cnt_ff != 4'd0) begin
         unique case (phase_ff)
            PH_SEEK_ONE: begin
               if (bit_now) phase_in = PH_SEEK_ZERO;
            end
            PH_SEEK_ZERO: begin
               if (!bit_now) begin
                  phase_in = PH_COUNT;
                  zrun_in  = ZRUN_W'(1);
               end
            end
            PH_COUNT: begin
               if (!bit_now) begin
                  if (zrun_ff != ZRUN_MAX) zrun_in = zrun_ff + 1'b1;
               end else if (zrun_ff >= cfg.min_zeros && zrun_ff <= cfg.max_zeros) begin
                  phase_in = PH_AFTER_ONE;
               end else begin
                  phase_in = PH_SEEK_ONE;
               end
            end
            PH_AFTER_ONE: begin
               if (bit_now) begin
                  phase_in = PH_SEEK_ZERO;
               end else begin
                  fidx_in  = '0;
                  phase_in = (cfg.position_bits == '0) ? PH_FLAGS : PH_POSITION;
               end
            end
            PH_POSITION: begin
               pos_in  = {pos_ff[POS_W-2:0], bit_now};
               crc_in  = crc_step(crc_ff, bit_now);
               fidx_in = fidx_ff + 1'b1;
               if (fidx_in >= cfg.position_bits) begin
                  fidx_in  = '0;
                  phase_in = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               flags_in = {flags_ff[0], bit_now};
               crc_in   = crc_step(crc_ff, bit_now);
               fidx_in  = fidx_ff + 1'b1;
               if (fidx_in >= PBITS_W'(FLAG_BITS)) begin
                  fidx_in  = '0;
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               rxcrc_in = {rxcrc_ff[CRC_W-2:0], ~bit_now};
               fidx_in  = fidx_ff + 1'b1;
               if (fidx_in >= PBITS_W'(CRC_W)) begin
                  fidx_in  = '0;
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign frame_ok = (phase_in == PH_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         phase_ff     <= PH_SEEK_ONE;
         zrun_ff      <= '0;
         fidx_ff      <= '0;
         pos_ff       <= '0;
         flags_ff     <= '0;
         rxcrc_ff     <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // beat register
         if (load) begin
            busy_ff <= 1'b1;
            byte_ff <= q_entry.line_byte;
            cnt_ff  <= q_entry.nbits;
            last_ff <= q_entry.last_byte;
         end else begin
            if (take) begin
               byte_ff <= {byte_ff[6:0], 1'b0};
               cnt_ff  <= cnt_ff - 1'b1;
            end
            if (finish && advance) busy_ff <= 1'b0;
         end

         // frame state, cleared after each result
         if (emit && advance) begin
            phase_ff <= PH_SEEK_ONE;
            zrun_ff  <= '0;
            fidx_ff  <= '0;
            pos_ff   <= '0;
            flags_ff <= '0;
            rxcrc_ff <= '0;
            crc_ff   <= '0;
         end else if (take) begin
            phase_ff <= phase_in;
            zrun_ff  <= zrun_in;
            fidx_ff  <= fidx_in;
            pos_ff   <= pos_in;
            flags_ff <= flags_in;
            rxcrc_ff <= rxcrc_in;
            crc_ff   <= crc_in;
         end

         // result register
         if (emit && advance) begin
            rsp_valid_ff <= 1'b1;
            ok_ff        <= frame_ok;
            rpos_ff      <= frame_ok ? pos_in : '0;
            err_ff       <= frame_ok && !flags_in[1];
            warn_ff      <= frame_ok && !flags_in[0];
            crcok_ff     <= frame_ok && (crc_in == rxcrc_in);
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_ok     = ok_ff;
   assign rsp_ch.position     = rpos_ff;
   assign rsp_ch.error_flag   = err_ff;
   assign rsp_ch.warning_flag = warn_ff;
   assign rsp_ch.crc_ok       = crcok_ff;

endmodule

`default_nettype wire

>>> rtl/core/biss_c_frame_parser.sv
// Top level of the BiSS-C position frame parser: config registers, front end,
// queue and bit-serial back end. Depends on bcfp_pkg, the bcfp_*_if interfaces,
// bcfp_front, bcfp_fifo and bcfp_back.
//
//   channel  dir  beat payload                                    handshake
//   req_ch   in   line_byte[7:0] (MSB first), last_byte           valid/ready
//   rsp_ch   out  frame_ok, position[31:0], error_flag,           valid/ready
//                 warning_flag, crc_ok
//   csr_ch   in   index[1:0] (0 position_bits, 1 min_zeros,       valid/ready
//                 2 max_zeros), data[6:0]
//
// Scanning: the back end scans one line bit per clock unless it is stalled on
//   rsp_ch; a byte wholly past the 128-bit frame capacity is passed with no bits
//   scanned. The next byte loads in the cycle the previous one finishes.
// A result is registered on the cycle the last bit of a last_byte beat is scanned.
// Reset is synchronous, active high; it clears the frame state and the queue
//   and loads the register defaults (26, 4, 40). No clearing pass.
// Stalls: a 4-beat queue decouples req_ch from the scanner; the scanner halts
//   only when it must post a result while rsp_ch holds one not yet taken.
// csr_ch is always ready; writes to index 3 are dropped.
`default_nettype none

module biss_c_frame_parser import bcfp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   bcfp_req_if.sink    req_ch,
   bcfp_rsp_if.source  rsp_ch,
   bcfp_csr_if.sink    csr_ch
);

   cfg_type   cfg_ff;
   logic      q_push, q_full, q_pop, q_valid;
   entry_type q_in_entry, q_out_entry;
   logic      csr_wr;

   // configuration registers
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_bits <= POSITION_BITS_RST;
         cfg_ff.min_zeros     <= MIN_ZEROS_RST;
         cfg_ff.max_zeros     <= MAX_ZEROS_RST;
      end else if (csr_wr) begin
         unique case (csr_ch.index)
            CSR_POSITION_BITS: cfg_ff.position_bits <= csr_ch.data[PBITS_W-1:0];
            CSR_MIN_ZEROS:     cfg_ff.min_zeros     <= csr_ch.data;
            CSR_MAX_ZEROS:     cfg_ff.max_zeros     <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // front: accept beats, tag with in-capacity bit count
   bcfp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_in_entry)
   );

   bcfp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_entry),
      .not_empty (q_valid)
   );

   // back: serial scan, CRC, result register
   bcfp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_entry (q_out_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // no result right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // a failed frame carries all-zero fields
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.frame_ok) |->
         (rsp_ch.position == '0 && !rsp_ch.error_flag &&
          !rsp_ch.warning_flag && !rsp_ch.crc_ok))
      else $error("failed frame with nonzero fields");

   // the queue is never popped while empty
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // a position_bits write lands in the register
   a_cfg_pbits: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_ch.index == CSR_POSITION_BITS) |=>
         (cfg_ff.position_bits == $past(csr_ch.data[PBITS_W-1:0])))
      else $error("position_bits write lost");

endmodule

`default_nettype wire
